@@ design/sdic_pkg.sv @@
package sdic_pkg;

  localparam int POSITION_BITS = 32;
  localparam int VALUE_BITS    = 64;
  localparam int MAG_BITS      = VALUE_BITS - 1;
  localparam int MAG_EXT       = MAG_BITS + 4;
  localparam int CFG_IDX_BITS  = 1;

  typedef logic [2:0]               status_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [VALUE_BITS-1:0]    value_t;
  typedef logic [MAG_BITS-1:0]      mag_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;

  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_EMPTY  = 3'd1;
  localparam status_t ST_NOTINT = 3'd2;
  localparam status_t ST_LARGE  = 3'd3;
  localparam status_t ST_RANGE  = 3'd4;
  localparam status_t ST_FAILED = 3'd5;

  localparam cfg_idx_t REG_RANGE_LOW  = 1'b0;
  localparam cfg_idx_t REG_RANGE_HIGH = 1'b1;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  localparam mag_t   MAG_LIMIT       = '1;
  localparam value_t RANGE_LOW_RST   = '0;
  localparam value_t RANGE_HIGH_RST  = {1'b0, MAG_LIMIT};
  localparam pos_t   POS_ONE         = pos_t'(1);

endpackage

@@ design/sdic_in_if.sv @@
interface sdic_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

@@ design/sdic_out_if.sv @@
interface sdic_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [63:0]      token_value;
  sdic_pkg::status_t       token_status;
  sdic_pkg::pos_t          token_line;
  sdic_pkg::pos_t          token_column;

  modport source (output valid, output token_value, output token_status,
                  output token_line, output token_column, input ready);
  modport sink   (input valid, input token_value, input token_status,
                  input token_line, input token_column, output ready);
endinterface

@@ design/sdic_cfg_if.sv @@
interface sdic_cfg_if;
  logic               valid;
  logic               ready;
  sdic_pkg::cfg_idx_t index;
  logic signed [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/strict_decimal_integer_checker_unit.sv @@
// Channel  Dir  Payload                                          Handshake
// in_ch    in   char_byte[7:0], end_of_input                     valid/ready
// out_ch   out  token_value[63:0] s, token_status[2:0],          valid/ready
//               token_line[31:0], token_column[31:0]
// cfg_ch   in   index[0] (0 range_low, 1 range_high), data[63:0] valid/ready
//
// One byte per cycle. A delimiter beat, or an end-of-input beat closing an open token,
// yields its result on out_ch in the cycle after acceptance; the path is the x10+digit
// add with overflow compare and, on close, the 64-bit negate and range compares.
// rst_n (sync, active low) clears token state, sticky failure and positions;
// range registers return to their defaults. in_ch stalls only while a result
// is held and out_ch.ready is low. cfg_ch is always ready.
module strict_decimal_integer_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  sdic_in_if.sink    in_ch,
  sdic_out_if.source out_ch,
  sdic_cfg_if.sink   cfg_ch
);

  sdic_pkg::value_t range_low_r, range_high_r;

  sdic_pkg::mag_t mag_r, mag_nxt;
  logic minus_r, minus_nxt;
  logic dig_seen_r, dig_seen_nxt;
  logic lead_zero_r, lead_zero_nxt;
  logic malf_r, malf_nxt;
  logic ovf_r, ovf_nxt;
  logic open_r, open_nxt;
  logic fail_r, fail_nxt;
  sdic_pkg::pos_t line_r, line_nxt;
  sdic_pkg::pos_t col_r, col_nxt;
  sdic_pkg::pos_t sline_r, sline_nxt;
  sdic_pkg::pos_t scol_r, scol_nxt;

  logic                out_valid_r, out_valid_nxt;
  sdic_pkg::value_t    value_r;
  sdic_pkg::status_t   status_r;
  sdic_pkg::pos_t      oline_r, ocol_r;

  logic in_fire;
  logic is_delim, is_minus, is_num;
  logic [3:0] dig;

  sdic_pkg::mag_t t_mag;
  logic t_minus, t_seen, t_lz, t_malf, t_ovf;
  logic [sdic_pkg::MAG_EXT-1:0] mag_sum;
  logic step_ovf;

  logic             bad_tok;
  sdic_pkg::value_t close_val;
  logic             in_range;
  sdic_pkg::status_t close_status;

  logic              emit;
  sdic_pkg::value_t  emit_val;
  sdic_pkg::status_t emit_status;
  sdic_pkg::pos_t    emit_line, emit_col;

  function automatic sdic_pkg::pos_t pos_inc(input sdic_pkg::pos_t v);
    pos_inc = (v == '1) ? v : v + sdic_pkg::POS_ONE;
  endfunction

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign is_delim = (in_ch.char_byte == sdic_pkg::CH_SPACE) ||
                    (in_ch.char_byte == sdic_pkg::CH_NEWLINE);
  assign is_minus = (in_ch.char_byte == sdic_pkg::CH_MINUS);
  assign is_num   = in_ch.char_byte inside {[sdic_pkg::CH_ZERO:sdic_pkg::CH_NINE]};
  assign dig      = in_ch.char_byte[3:0];

  // token state as seen by a token byte: fresh when no token is open
  assign t_mag   = open_r ? mag_r : '0;
  assign t_minus = open_r && minus_r;
  assign t_seen  = open_r && dig_seen_r;
  assign t_lz    = open_r && lead_zero_r;
  assign t_malf  = open_r && malf_r;
  assign t_ovf   = open_r && ovf_r;

  assign mag_sum  = {1'b0, t_mag, 3'b000} + {3'b000, t_mag, 1'b0}
                    + {{(sdic_pkg::MAG_EXT-4){1'b0}}, dig};
  assign step_ovf = mag_sum > {4'b0000, sdic_pkg::MAG_LIMIT};

  assign bad_tok   = malf_r || !dig_seen_r || (minus_r && lead_zero_r);
  assign close_val = minus_r ? -{1'b0, mag_r} : {1'b0, mag_r};
  assign in_range  = ($signed(close_val) >= $signed(range_low_r)) &&
                     ($signed(close_val) <= $signed(range_high_r));

  always_comb begin
    if (fail_r) begin
      close_status = sdic_pkg::ST_FAILED;
    end else if (bad_tok) begin
      close_status = sdic_pkg::ST_NOTINT;
    end else if (ovf_r) begin
      close_status = sdic_pkg::ST_LARGE;
    end else if (!in_range) begin
      close_status = sdic_pkg::ST_RANGE;
    end else begin
      close_status = sdic_pkg::ST_OK;
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    minus_nxt     = minus_r;
    dig_seen_nxt  = dig_seen_r;
    lead_zero_nxt = lead_zero_r;
    malf_nxt      = malf_r;
    ovf_nxt       = ovf_r;
    open_nxt      = open_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    sline_nxt     = sline_r;
    scol_nxt      = scol_r;
    emit          = 1'b0;
    emit_status   = close_status;
    emit_line     = sline_r;
    emit_col      = scol_r;
    if (in_fire) begin
      if (in_ch.end_of_input) begin
        emit     = open_r;
        open_nxt = 1'b0;
      end else if (is_delim) begin
        emit     = 1'b1;
        open_nxt = 1'b0;
        if (!open_r) begin
          emit_status = fail_r ? sdic_pkg::ST_FAILED : sdic_pkg::ST_EMPTY;
          emit_line   = line_r;
          emit_col    = col_r;
        end
        if (in_ch.char_byte == sdic_pkg::CH_NEWLINE) begin
          line_nxt = pos_inc(line_r);
          col_nxt  = sdic_pkg::POS_ONE;
        end else begin
          col_nxt = pos_inc(col_r);
        end
      end else begin
        open_nxt      = 1'b1;
        mag_nxt       = t_mag;
        minus_nxt     = t_minus;
        dig_seen_nxt  = t_seen;
        lead_zero_nxt = t_lz;
        malf_nxt      = t_malf;
        ovf_nxt       = t_ovf;
        if (!open_r) begin
          sline_nxt = line_r;
          scol_nxt  = col_r;
        end
        if (is_minus) begin
          if (t_minus || t_seen) begin
            malf_nxt = 1'b1;
          end else begin
            minus_nxt = 1'b1;
          end
        end else if (is_num) begin
          if (!t_seen) begin
            dig_seen_nxt  = 1'b1;
            lead_zero_nxt = (dig == 4'd0);
          end else if (t_lz) begin
            malf_nxt = 1'b1;
          end
          if (!t_ovf) begin
            if (step_ovf) begin
              ovf_nxt = 1'b1;
            end else begin
              mag_nxt = mag_sum[sdic_pkg::MAG_BITS-1:0];
            end
          end
        end else begin
          malf_nxt = 1'b1;
        end
        col_nxt = pos_inc(col_r);
      end
    end
    emit_val      = (emit_status == sdic_pkg::ST_OK) ? close_val : '0;
    fail_nxt      = fail_r || (emit && (emit_status != sdic_pkg::ST_OK));
    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= sdic_pkg::RANGE_LOW_RST;
      range_high_r <= sdic_pkg::RANGE_HIGH_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == sdic_pkg::REG_RANGE_LOW) begin
        range_low_r <= cfg_ch.data;
      end else begin
        range_high_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r       <= '0;
      minus_r     <= 1'b0;
      dig_seen_r  <= 1'b0;
      lead_zero_r <= 1'b0;
      malf_r      <= 1'b0;
      ovf_r       <= 1'b0;
      open_r      <= 1'b0;
      fail_r      <= 1'b0;
      line_r      <= sdic_pkg::POS_ONE;
      col_r       <= sdic_pkg::POS_ONE;
      sline_r     <= sdic_pkg::POS_ONE;
      scol_r      <= sdic_pkg::POS_ONE;
      out_valid_r <= 1'b0;
    end else begin
      mag_r       <= mag_nxt;
      minus_r     <= minus_nxt;
      dig_seen_r  <= dig_seen_nxt;
      lead_zero_r <= lead_zero_nxt;
      malf_r      <= malf_nxt;
      ovf_r       <= ovf_nxt;
      open_r      <= open_nxt;
      fail_r      <= fail_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      sline_r     <= sline_nxt;
      scol_r      <= scol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value_r  <= emit_val;
      status_r <= emit_status;
      oline_r  <= emit_line;
      ocol_r   <= emit_col;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_value  = value_r;
  assign out_ch.token_status = status_r;
  assign out_ch.token_line   = oline_r;
  assign out_ch.token_column = ocol_r;

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != sdic_pkg::ST_OK) |-> fail_r)
    else $error("failing beat without sticky failure");

  a_failed_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(emit) && $past(fail_r) |-> status_r == sdic_pkg::ST_FAILED)
    else $error("beat after failure not reported as failed");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != '0) && (col_r != '0) && (sline_r != '0) && (scol_r != '0))
    else $error("position counter wrapped");

  a_value_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != sdic_pkg::ST_OK) |-> value_r == '0)
    else $error("nonzero value on error beat");

endmodule
